/* hw/rtl/tpm_pkg.sv */
// tree parity machine package: field widths, operation codes, defaults
// and the weight clipping function shared by the core
// depends on nothing
`default_nettype none

package tpm_pkg;

  localparam int HIDDEN_UNITS_DEF    = 3;
  localparam int INPUTS_PER_UNIT_DEF = 16;

  localparam int OP_W     = 3;
  localparam int INDEX_W  = 6;
  localparam int VALUE_W  = 8;
  localparam int WEIGHT_W = 8;
  localparam int BOUND_W  = 7;
  localparam int TAU_W    = 2;

  localparam logic [BOUND_W-1:0] BOUND_RESET = 7'd3;

  localparam logic [OP_W-1:0] OP_STORE    = 3'd0;
  localparam logic [OP_W-1:0] OP_EVALUATE = 3'd1;
  localparam logic [OP_W-1:0] OP_LEARN    = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE    = 3'd3;
  localparam logic [OP_W-1:0] OP_READ     = 3'd4;

  localparam logic signed [TAU_W-1:0] TAU_POS = 2'sb01;
  localparam logic signed [TAU_W-1:0] TAU_NEG = 2'sb11;

  // clamp a widened weight to [-bound, bound]
  function automatic logic [WEIGHT_W-1:0] clip_weight(
    input logic signed [WEIGHT_W:0] w,
    input logic [BOUND_W-1:0]       bound
  );
    logic signed [WEIGHT_W:0] hi;
    logic signed [WEIGHT_W:0] lo;
    logic signed [WEIGHT_W:0] res;
    hi = $signed({2'b00, bound});
    lo = -hi;
    if (w > hi) begin
      res = hi;
    end else if (w < lo) begin
      res = lo;
    end else begin
      res = w;
    end
    return res[WEIGHT_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/tpm_ram.sv */
// simple dual port ram, one write and one registered read port
// depends on nothing
`default_nettype none

module tpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/tree_parity_machine_core.sv */
// Tree parity machine with Hebbian learning. Weights and stimuli sit in two
// small rams of HIDDEN_UNITS*INPUTS_PER_UNIT entries with a registered read.
// After reset a clearing pass over all HIDDEN_UNITS*INPUTS_PER_UNIT entries (48 at
// the defaults) zeroes both rams; requests are stalled meanwhile, the
// weight_bound register may be written at any time. Store, write and unknown
// ops go from the request through the done state to the result register, a
// weight read passes the read state first. Evaluate and learn walk every
// weight once through the single weight read port, one a cycle, then finish.
// One request is worked on at a time; a finished result waits in the output
// register while the next request is taken.
// depends on tpm_pkg and tpm_ram
`default_nettype none

module tree_parity_machine_core #(
  parameter int HIDDEN_UNITS    = tpm_pkg::HIDDEN_UNITS_DEF,
  parameter int INPUTS_PER_UNIT = tpm_pkg::INPUTS_PER_UNIT_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic        [tpm_pkg::BOUND_W-1:0]  cfg_data,
  input  wire logic                                req_valid,
  output logic                                     req_stall,
  input  wire logic        [tpm_pkg::OP_W-1:0]     op,
  input  wire logic        [tpm_pkg::INDEX_W-1:0]  index,
  input  wire logic signed [tpm_pkg::VALUE_W-1:0]  value,
  output logic                                     res_valid,
  input  wire logic                                res_stall,
  output logic signed      [tpm_pkg::TAU_W-1:0]    tau,
  output logic signed      [tpm_pkg::WEIGHT_W-1:0] weight_out,
  output logic                                     updated
);

  localparam int TOTAL  = HIDDEN_UNITS * INPUTS_PER_UNIT;
  localparam int ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int UNIT_W = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
  localparam int IN_W   = (INPUTS_PER_UNIT > 1) ? $clog2(INPUTS_PER_UNIT) : 1;
  localparam int XW     = ((ADDR_W > tpm_pkg::INDEX_W) ? ADDR_W : tpm_pkg::INDEX_W) + 1;
  localparam int ACC_W  = $clog2(INPUTS_PER_UNIT) + tpm_pkg::WEIGHT_W + 1;
  localparam int WW     = tpm_pkg::WEIGHT_W;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_WALK  = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TOTAL - 1);
  localparam logic [IN_W-1:0]   LAST_IN   = IN_W'(INPUTS_PER_UNIT - 1);

  logic [2:0]                 state;
  logic [tpm_pkg::BOUND_W-1:0] weight_bound;
  logic [HIDDEN_UNITS-1:0]    hidden_signs;
  logic                       local_tau;

  // walk counters, also used as the clearing address
  logic [ADDR_W-1:0] walk_addr;
  logic [UNIT_W-1:0] walk_unit;
  logic [IN_W-1:0]   walk_inp;
  logic              issuing;
  logic              walk_learn;
  logic              learn_agree;
  logic              eval_par;

  // read data stage
  logic              p_valid;
  logic [ADDR_W-1:0] p_addr;
  logic [UNIT_W-1:0] p_unit;
  logic              p_last_in;
  logic              p_last;

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] w_ext;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] sum;
  logic                    unit_neg;

  logic signed [WW:0] w9;
  logic signed [WW:0] delta;
  logic               learn_active;

  logic          acc_in_range;
  logic [WW-1:0] r_wout;
  logic          r_upd;

  logic [XW-1:0]     idx_ext;
  logic [ADDR_W-1:0] idx_addr;
  logic              in_range;
  logic              accept;
  logic              out_free;

  logic              wt_we;
  logic [ADDR_W-1:0] wt_waddr;
  logic [WW-1:0]     wt_wdata;
  logic [ADDR_W-1:0] rd_addr;
  logic [WW-1:0]     wt_rdata;
  logic              st_we;
  logic [ADDR_W-1:0] st_waddr;
  logic              st_wdata;
  logic              st_rdata;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !res_valid || !res_stall;

  assign idx_ext  = XW'(index);
  assign idx_addr = idx_ext[ADDR_W-1:0];
  assign in_range = idx_ext < XW'(TOTAL);

  assign rd_addr = (state == ST_IDLE) ? idx_addr : walk_addr;

  // evaluate datapath: signed sum of weight times stimulus
  assign w_ext    = ACC_W'($signed(wt_rdata));
  assign term     = st_rdata ? -w_ext : w_ext;
  assign sum      = acc + term;
  assign unit_neg = sum[ACC_W-1] || (sum == '0);

  // learn datapath: step by stimulus times tau where the unit agrees
  assign learn_active = learn_agree && (hidden_signs[p_unit] == local_tau);
  assign delta        = !learn_active ? '0 :
                        (st_rdata ^ local_tau) ? -(WW+1)'(1) : (WW+1)'(1);
  assign w9           = (WW+1)'($signed(wt_rdata)) + delta;

  tpm_ram #(.WIDTH(WW), .DEPTH(TOTAL)) u_weight_ram (
    .clk   (clk),
    .we    (wt_we),
    .waddr (wt_waddr),
    .wdata (wt_wdata),
    .raddr (rd_addr),
    .rdata (wt_rdata)
  );

  tpm_ram #(.WIDTH(1), .DEPTH(TOTAL)) u_stim_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (rd_addr),
    .rdata (st_rdata)
  );

  always_comb begin
    wt_we    = 1'b0;
    wt_waddr = walk_addr;
    wt_wdata = '0;
    st_we    = 1'b0;
    st_waddr = walk_addr;
    st_wdata = 1'b0;
    if (state == ST_CLEAR) begin
      wt_we = 1'b1;
      st_we = 1'b1;
    end else if (accept && in_range && (op == tpm_pkg::OP_STORE)) begin
      st_we    = 1'b1;
      st_waddr = idx_addr;
      st_wdata = value[tpm_pkg::VALUE_W-1];
    end else if (accept && in_range && (op == tpm_pkg::OP_WRITE)) begin
      wt_we    = 1'b1;
      wt_waddr = idx_addr;
      wt_wdata = tpm_pkg::clip_weight((WW+1)'(value), weight_bound);
    end else if ((state == ST_WALK) && p_valid && walk_learn) begin
      wt_we    = 1'b1;
      wt_waddr = p_addr;
      wt_wdata = tpm_pkg::clip_weight(w9, weight_bound);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_bound <= tpm_pkg::BOUND_RESET;
    end else if (cfg_we) begin
      weight_bound <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      walk_addr    <= '0;
      walk_unit    <= '0;
      walk_inp     <= '0;
      issuing      <= 1'b0;
      p_valid      <= 1'b0;
      hidden_signs <= '0;
      local_tau    <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (walk_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end else begin
            walk_addr <= walk_addr + ADDR_W'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            r_wout       <= '0;
            r_upd        <= 1'b0;
            acc_in_range <= in_range;
            walk_addr    <= '0;
            walk_unit    <= '0;
            walk_inp     <= '0;
            acc          <= '0;
            eval_par     <= 1'b0;
            learn_agree  <= (local_tau == value[tpm_pkg::VALUE_W-1]);
            unique case (op)
              tpm_pkg::OP_EVALUATE: begin
                walk_learn <= 1'b0;
                issuing    <= 1'b1;
                state      <= ST_WALK;
              end
              tpm_pkg::OP_LEARN: begin
                walk_learn <= 1'b1;
                issuing    <= 1'b1;
                r_upd      <= (local_tau == value[tpm_pkg::VALUE_W-1]);
                state      <= ST_WALK;
              end
              tpm_pkg::OP_READ: begin
                state <= ST_READ;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_WALK: begin
          p_valid <= issuing;
          if (issuing) begin
            p_addr    <= walk_addr;
            p_unit    <= walk_unit;
            p_last_in <= (walk_inp == LAST_IN);
            p_last    <= (walk_addr == LAST_ADDR);
            if (walk_addr == LAST_ADDR) begin
              issuing <= 1'b0;
            end else begin
              walk_addr <= walk_addr + ADDR_W'(1);
              if (walk_inp == LAST_IN) begin
                walk_inp  <= '0;
                walk_unit <= walk_unit + UNIT_W'(1);
              end else begin
                walk_inp <= walk_inp + IN_W'(1);
              end
            end
          end
          if (p_valid && !walk_learn) begin
            if (p_last_in) begin
              acc                  <= '0;
              hidden_signs[p_unit] <= unit_neg;
              eval_par             <= eval_par ^ unit_neg;
              if (p_last) begin
                local_tau <= eval_par ^ unit_neg;
              end
            end else begin
              acc <= sum;
            end
          end
          if (p_valid && p_last) begin
            state <= ST_DONE;
          end
        end
        ST_READ: begin
          r_wout <= acc_in_range ? wt_rdata : '0;
          state  <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            res_valid  <= 1'b1;
            tau        <= local_tau ? tpm_pkg::TAU_NEG : tpm_pkg::TAU_POS;
            weight_out <= r_wout;
            updated    <= r_upd;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pipe_in_walk: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> (state == ST_WALK))
    else $error("read data stage live outside a walk");

  a_learn_wb_addr: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && p_valid && walk_learn) |-> (wt_waddr == $past(rd_addr)))
    else $error("learn write-back address does not follow its read");

  a_tau_legal: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (tau == tpm_pkg::TAU_POS || tau == tpm_pkg::TAU_NEG))
    else $error("result tau is not plus or minus one");

  a_clear_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR && walk_addr == LAST_ADDR) |=> (state == ST_IDLE))
    else $error("clearing pass did not end at the last entry");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free) |=> (res_valid && state == ST_IDLE))
    else $error("finished result not loaded into output register");
`endif

endmodule

`default_nettype wire
